// ----- src/perb_pkg.sv -----
// perb_pkg: shared types, constants and codes of the priority event retry buffer.
// Used by perb_mem, perb_ctrl and priority_event_retry_buffer. No dependencies.
`default_nettype none
package perb_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LINK_W  = SLOT_W + 1;
  localparam int PAY_W   = 32;
  localparam int PRIO_W  = 3;
  localparam int USER_W  = 16;
  localparam int RETRY_W = 8;
  localparam int FLAG_W  = 4;

  // link: top bit set means nil
  typedef logic [LINK_W-1:0] link_t;
  localparam link_t LINK_NIL = link_t'(1) << SLOT_W;

  localparam logic [FLAG_W-1:0] F_USED   = 4'h1;
  localparam logic [FLAG_W-1:0] F_ACTIVE = 4'h2;
  localparam logic [FLAG_W-1:0] F_PROC   = 4'h4;
  localparam logic [FLAG_W-1:0] F_FAIL   = 4'h8;

  localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_GET     = 2'd1,
    ACT_DONE    = 2'd2,
    ACT_RESTORE = 2'd3
  } action_t;

  typedef struct packed {
    logic [FLAG_W-1:0]  flags;
    link_t              nxt;
    link_t              prv;
    logic [PRIO_W-1:0]  prio;
    logic [USER_W-1:0]  owner;
    logic [PAY_W-1:0]   data;
    logic [RETRY_W-1:0] retries;
  } ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    ent_t              wr_data;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FF_STEP, S_FF_EV, S_VA0, S_VA_RD, S_VA_EV, S_VB0, S_VB_RD, S_VB_EV,
    S_NW_WR, S_NW_T_RD, S_NW_T_WR, S_GT_RD, S_GT_EV, S_DN_RD, S_DN_EV,
    S_RS_RD, S_RS_EV, S_WK_NX, S_UL0, S_UL_P_RD, S_UL_P_WR, S_UL_TL,
    S_UL_N_RD, S_UL_N_WR, S_NP0, S_NP_RD, S_NP_EV, S_FIN
  } state_t;

  typedef struct packed {
    logic              ok;
    logic [PAY_W-1:0]  payload;
    logic [USER_W-1:0] user;
    logic [PRIO_W-1:0] prio;
    logic              evicted;
    logic              nothing_pending;
  } result_t;

endpackage
`default_nettype wire

// ----- src/perb_mem.sv -----
// perb_mem: slot memory, one write and one registered read per cycle.
// Per-slot valid bits make unwritten slots read as free with nil links. Uses perb_pkg.
`default_nettype none
module perb_mem
  import perb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mem_req_t req,
  output ent_t          rd_ent
);

  ent_t             mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  ent_t             rdata_r;
  logic             rvld_r;
  logic             fwd;

  assign fwd = req.wr_en && (req.wr_addr == req.rd_addr);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // array write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read, write data forwarded on same address
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= fwd ? req.wr_data : mem[req.rd_addr];
      rvld_r  <= fwd | vld_r[req.rd_addr];
    end
  end

  // unwritten slot: free, nil links
  always_comb begin
    rd_ent = rdata_r;
    if (!rvld_r) begin
      rd_ent.flags = '0;
      rd_ent.nxt   = LINK_NIL;
      rd_ent.prv   = LINK_NIL;
    end
  end

endmodule
`default_nettype wire

// ----- src/perb_ctrl.sv -----
// perb_ctrl: sequencer that walks the slot chain through perb_mem.
// Read-modify-write of slot entries, unlink subroutine, pending scan. Uses perb_pkg.
`default_nettype none
module perb_ctrl
  import perb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic [PAY_W-1:0]   in_payload,
  input  wire logic [PRIO_W-1:0]  in_priority,
  input  wire logic [USER_W-1:0]  in_user,
  input  wire logic               in_delivered,
  input  wire logic [RETRY_W-1:0] retry_max,
  output mem_req_t                req,
  input  wire ent_t               rd_ent,
  output logic                    res_valid,
  input  wire logic               res_take,
  output result_t                 res
);

  state_t             state_r, state_nxt, ret_r, ret_nxt;
  action_t            act_r, act_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic [PRIO_W-1:0]  prio_r, prio_nxt, low_r, low_nxt;
  logic [USER_W-1:0]  user_r, user_nxt;
  logic               deliv_r, deliv_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt, probe_r, probe_nxt;
  link_t              tail_r, tail_nxt, nx_r, nx_nxt, ul_link_r, ul_link_nxt;
  logic [SLOT_W-1:0]  s_r, s_nxt, cnt_r, cnt_nxt, w_r, w_nxt, ul_s_r, ul_s_nxt;
  ent_t               ul_ent_r, ul_ent_nxt;
  result_t            res_r, res_nxt;

  logic               active, pending, last, wr_f;
  link_t              fol;
  logic [PRIO_W-1:0]  low_min;
  logic [SLOT_W-1:0]  probe_inc;
  logic [FLAG_W-1:0]  f_new;
  logic [RETRY_W-1:0] r_new;
  ent_t               ent_mod;

  assign active    = (rd_ent.flags & (F_USED | F_ACTIVE)) == (F_USED | F_ACTIVE);
  assign pending   = active && ((rd_ent.flags & (F_PROC | F_FAIL)) == '0);
  assign fol       = rd_ent.nxt;
  assign last      = (cnt_r == SLOT_LAST) || fol[SLOT_W];
  assign low_min   = (rd_ent.prio < low_r) ? rd_ent.prio : low_r;
  assign probe_inc = (probe_r == SLOT_LAST) ? '0 : probe_r + 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res       = res_r;
  assign wr_f      = 1'b0;

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      head_r  <= '0;
      tail_r  <= LINK_NIL;
      probe_r <= SLOT_LAST;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    pay_r     <= pay_nxt;
    prio_r    <= prio_nxt;
    user_r    <= user_nxt;
    deliv_r   <= deliv_nxt;
    low_r     <= low_nxt;
    nx_r      <= nx_nxt;
    ul_link_r <= ul_link_nxt;
    s_r       <= s_nxt;
    cnt_r     <= cnt_nxt;
    w_r       <= w_nxt;
    ul_s_r    <= ul_s_nxt;
    ul_ent_r  <= ul_ent_nxt;
    res_r     <= res_nxt;
  end

  // next state and memory requests
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    act_nxt     = act_r;
    pay_nxt     = pay_r;
    prio_nxt    = prio_r;
    user_nxt    = user_r;
    deliv_nxt   = deliv_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    probe_nxt   = probe_r;
    low_nxt     = low_r;
    nx_nxt      = nx_r;
    ul_link_nxt = ul_link_r;
    s_nxt       = s_r;
    cnt_nxt     = cnt_r;
    w_nxt       = w_r;
    ul_s_nxt    = ul_s_r;
    ul_ent_nxt  = ul_ent_r;
    res_nxt     = res_r;
    f_new       = '0;
    r_new       = '0;
    ent_mod     = rd_ent;
    req         = '0;
    req.wr_en   = wr_f;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = action_t'(in_action);
          pay_nxt   = in_payload;
          prio_nxt  = in_priority;
          user_nxt  = in_user;
          deliv_nxt = in_delivered;
          res_nxt   = '0;
          s_nxt     = head_r;
          cnt_nxt   = '0;
          unique case (action_t'(in_action))
            ACT_ADD: begin
              if (in_user == '0) begin
                state_nxt = S_NP0;
              end else if (tail_r[SLOT_W]) begin
                w_nxt     = head_r;
                state_nxt = S_NW_WR;
              end else begin
                state_nxt = S_FF_STEP;
              end
            end
            ACT_GET:  state_nxt = S_GT_RD;
            ACT_DONE: state_nxt = S_DN_RD;
            default: begin
              res_nxt.ok = 1'b1;
              state_nxt  = S_RS_RD;
            end
          endcase
        end
      end

      // rotating probe for a free slot
      S_FF_STEP: begin
        probe_nxt   = probe_inc;
        req.rd_en   = 1'b1;
        req.rd_addr = probe_inc;
        state_nxt   = S_FF_EV;
      end
      S_FF_EV: begin
        if (rd_ent.flags == '0) begin
          w_nxt     = probe_r;
          state_nxt = S_NW_WR;
        end else if (cnt_r == SLOT_LAST) begin
          state_nxt = S_VA0;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_FF_STEP;
        end
      end

      // victim walk one: lowest priority, or a free slot on the chain
      S_VA0: begin
        s_nxt     = head_r;
        cnt_nxt   = '0;
        low_nxt   = PRIO_MAX;
        state_nxt = S_VA_RD;
      end
      S_VA_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = s_r;
        state_nxt   = S_VA_EV;
      end
      S_VA_EV: begin
        if (rd_ent.flags == '0) begin
          w_nxt     = s_r;
          state_nxt = S_NW_WR;
        end else begin
          low_nxt = low_min;
          if (last) begin
            state_nxt = S_VB0;
          end else begin
            s_nxt     = fol[SLOT_W-1:0];
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_VA_RD;
          end
        end
      end

      // victim walk two: oldest entry at that priority
      S_VB0: begin
        s_nxt   = head_r;
        cnt_nxt = '0;
        if (low_r > prio_r) begin
          state_nxt = S_NP0;
        end else begin
          state_nxt = S_VB_RD;
        end
      end
      S_VB_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = s_r;
        state_nxt   = S_VB_EV;
      end
      S_VB_EV: begin
        if (rd_ent.prio == low_r) begin
          w_nxt           = s_r;
          res_nxt.evicted = (rd_ent.flags & F_ACTIVE) != '0;
          ul_s_nxt        = s_r;
          ul_ent_nxt      = rd_ent;
          ret_nxt         = S_NW_WR;
          state_nxt       = S_UL0;
        end else if (last) begin
          state_nxt = S_NP0;
        end else begin
          s_nxt     = fol[SLOT_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_VB_RD;
        end
      end

      // write new event, then link it behind the tail
      S_NW_WR: begin
        req.wr_en           = 1'b1;
        req.wr_addr         = w_r;
        req.wr_data.flags   = F_USED | F_ACTIVE;
        req.wr_data.nxt     = LINK_NIL;
        req.wr_data.prv     = tail_r;
        req.wr_data.prio    = prio_r;
        req.wr_data.owner   = user_r;
        req.wr_data.data    = pay_r;
        req.wr_data.retries = '0;
        res_nxt.ok          = 1'b1;
        if (tail_r[SLOT_W]) begin
          tail_nxt  = {1'b0, w_r};
          state_nxt = S_NP0;
        end else begin
          state_nxt = S_NW_T_RD;
        end
      end
      S_NW_T_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = tail_r[SLOT_W-1:0];
        state_nxt   = S_NW_T_WR;
      end
      S_NW_T_WR: begin
        ent_mod.nxt = {1'b0, w_r};
        req.wr_en   = 1'b1;
        req.wr_addr = tail_r[SLOT_W-1:0];
        req.wr_data = ent_mod;
        tail_nxt    = {1'b0, w_r};
        state_nxt   = S_NP0;
      end

      // get: first pending event, owner filtered
      S_GT_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = s_r;
        state_nxt   = S_GT_EV;
      end
      S_GT_EV: begin
        if (pending && (user_r == '0 || user_r == rd_ent.owner)) begin
          ent_mod.flags   = rd_ent.flags | F_PROC;
          req.wr_en       = 1'b1;
          req.wr_addr     = s_r;
          req.wr_data     = ent_mod;
          res_nxt.ok      = 1'b1;
          res_nxt.payload = rd_ent.data;
          res_nxt.user    = rd_ent.owner;
          res_nxt.prio    = rd_ent.prio;
          state_nxt       = S_NP0;
        end else if (last) begin
          state_nxt = S_NP0;
        end else begin
          s_nxt     = fol[SLOT_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_GT_RD;
        end
      end

      // done: delete or fail in-flight events
      S_DN_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = s_r;
        state_nxt   = S_DN_EV;
      end
      S_DN_EV: begin
        nx_nxt    = fol;
        state_nxt = S_WK_NX;
        if ((rd_ent.flags & F_PROC) != '0) begin
          f_new         = rd_ent.flags & ~F_PROC;
          ent_mod.flags = f_new;
          if (active && deliv_r) begin
            ul_s_nxt   = s_r;
            ul_ent_nxt = ent_mod;
            ret_nxt    = S_WK_NX;
            state_nxt  = S_UL0;
          end else begin
            if (active) begin
              ent_mod.flags = f_new | F_FAIL;
            end
            req.wr_en   = 1'b1;
            req.wr_addr = s_r;
            req.wr_data = ent_mod;
          end
        end
      end

      // restore: requeue, count retries, drop at the limit
      S_RS_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = s_r;
        state_nxt   = S_RS_EV;
      end
      S_RS_EV: begin
        nx_nxt    = fol;
        state_nxt = S_WK_NX;
        if ((rd_ent.flags & (F_PROC | F_FAIL)) != '0) begin
          ent_mod.flags = rd_ent.flags & ~(F_PROC | F_FAIL);
          r_new         = rd_ent.retries + 1'b1;
          if (active && retry_max != '0) begin
            ent_mod.retries = r_new;
          end
          if (active && retry_max != '0 && r_new >= retry_max) begin
            res_nxt.ok = 1'b0;
            ul_s_nxt   = s_r;
            ul_ent_nxt = ent_mod;
            ret_nxt    = S_WK_NX;
            state_nxt  = S_UL0;
          end else begin
            req.wr_en   = 1'b1;
            req.wr_addr = s_r;
            req.wr_data = ent_mod;
          end
        end
      end

      // advance along the saved link
      S_WK_NX: begin
        if (nx_r[SLOT_W] || cnt_r == SLOT_LAST) begin
          state_nxt = S_NP0;
        end else begin
          s_nxt     = nx_r[SLOT_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = (act_r == ACT_DONE) ? S_DN_RD : S_RS_RD;
        end
      end

      // unlink subroutine; slot keeps its links
      S_UL0: begin
        if (ul_ent_r.flags == '0) begin
          state_nxt = ret_r;
        end else begin
          ent_mod       = ul_ent_r;
          ent_mod.flags = '0;
          req.wr_en     = 1'b1;
          req.wr_addr   = ul_s_r;
          req.wr_data   = ent_mod;
          if (ul_s_r != head_r) begin
            state_nxt = ul_ent_r.prv[SLOT_W] ? S_UL_TL : S_UL_P_RD;
          end else if (tail_r != {1'b0, ul_s_r}) begin
            if (!ul_ent_r.nxt[SLOT_W]) begin
              head_nxt    = ul_ent_r.nxt[SLOT_W-1:0];
              ul_link_nxt = LINK_NIL;
              state_nxt   = S_UL_N_RD;
            end else begin
              state_nxt = ret_r;
            end
          end else begin
            tail_nxt  = LINK_NIL;
            state_nxt = ret_r;
          end
        end
      end
      S_UL_P_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = ul_ent_r.prv[SLOT_W-1:0];
        state_nxt   = S_UL_P_WR;
      end
      S_UL_P_WR: begin
        ent_mod.nxt = ul_ent_r.nxt;
        req.wr_en   = 1'b1;
        req.wr_addr = ul_ent_r.prv[SLOT_W-1:0];
        req.wr_data = ent_mod;
        state_nxt   = S_UL_TL;
      end
      S_UL_TL: begin
        if (tail_r == {1'b0, ul_s_r}) begin
          tail_nxt  = ul_ent_r.prv;
          state_nxt = ret_r;
        end else if (!ul_ent_r.nxt[SLOT_W]) begin
          ul_link_nxt = ul_ent_r.prv;
          state_nxt   = S_UL_N_RD;
        end else begin
          state_nxt = ret_r;
        end
      end
      S_UL_N_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = ul_ent_r.nxt[SLOT_W-1:0];
        state_nxt   = S_UL_N_WR;
      end
      S_UL_N_WR: begin
        ent_mod.prv = ul_link_r;
        req.wr_en   = 1'b1;
        req.wr_addr = ul_ent_r.nxt[SLOT_W-1:0];
        req.wr_data = ent_mod;
        state_nxt   = ret_r;
      end

      // pending scan for the status bit
      S_NP0: begin
        s_nxt                   = head_r;
        cnt_nxt                 = '0;
        res_nxt.nothing_pending = 1'b1;
        state_nxt               = S_NP_RD;
      end
      S_NP_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = s_r;
        state_nxt   = S_NP_EV;
      end
      S_NP_EV: begin
        if (pending) begin
          res_nxt.nothing_pending = 1'b0;
          state_nxt               = S_FIN;
        end else if (last) begin
          state_nxt = S_FIN;
        end else begin
          s_nxt     = fol[SLOT_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_NP_RD;
        end
      end

      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // a request, once taken, keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a request was in progress");

  // no memory traffic while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!req.wr_en && !req.rd_en))
    else $error("memory access while idle");

  // a taken result returns the block to idle
  a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_take) |=> in_ready)
    else $error("result taken but block not idle");

  // unlink never returns into itself
  a_ret_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UL0) |-> (ret_r == S_NW_WR || ret_r == S_WK_NX))
    else $error("bad unlink return state");

endmodule
`default_nettype wire

// ----- src/priority_event_retry_buffer.sv -----
// Priority event retry buffer: a 16-slot event store kept as a doubly linked
// chain in arrival order, with add, get, done and restore requests.
//
// Input channel in_valid/in_ready carries one request; out_valid/out_ready
// returns exactly one result per request. Requests are handled one at a time
// by a sequencer that reads and writes one slot entry per cycle in a slot
// memory with a registered read. Before out_valid, a get walks the chain
// and then runs the pending scan; done and restore walk the chain, unlink
// each deleted event and run the scan; an add into a full store runs a
// probe pass, two victim walks, unlink, relink and the pending scan.
// The result is held in an output register; the next request is taken as
// soon as the sequencer is idle, even while that result still waits, and a
// finished request waits in place if the output register is still full.
// cfg_we/cfg_wdata write retry cap; user writes only while idle, unchecked.
// Reset (rst_n low, synchronous) clears all slots, links, head, tail and
// probe at once through per-slot valid bits; no clearing pass is needed.
// Depends on perb_pkg, perb_mem and perb_ctrl.
`default_nettype none
module priority_event_retry_buffer
  import perb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic [PAY_W-1:0]   in_payload,
  input  wire logic [PRIO_W-1:0]  in_priority_req,
  input  wire logic [USER_W-1:0]  in_user_id,
  input  wire logic               in_delivered,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_ok,
  output logic [PAY_W-1:0]        out_payload,
  output logic [USER_W-1:0]       out_user,
  output logic [PRIO_W-1:0]       out_priority,
  output logic                    out_evicted_active,
  output logic                    out_nothing_pending,
  input  wire logic               cfg_we,
  input  wire logic [RETRY_W-1:0] cfg_wdata
);

  mem_req_t           req;
  ent_t               rd_ent;
  result_t            res, out_r;
  logic               res_valid, res_take, out_valid_r;
  logic [RETRY_W-1:0] retry_max_r;

  assign res_take = !out_valid_r || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_max_r <= '0;
    end else if (cfg_we) begin
      retry_max_r <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = out_r.ok;
  assign out_payload         = out_r.payload;
  assign out_user            = out_r.user;
  assign out_priority        = out_r.prio;
  assign out_evicted_active  = out_r.evicted;
  assign out_nothing_pending = out_r.nothing_pending;

  perb_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rd_ent (rd_ent)
  );

  perb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_payload   (in_payload),
    .in_priority  (in_priority_req),
    .in_user      (in_user_id),
    .in_delivered (in_delivered),
    .retry_max    (retry_max_r),
    .req          (req),
    .rd_ent       (rd_ent),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for priority_event_retry_buffer: random and directed requests,
// checked against a cycle-free predictor of the slot chain. Depends on perb_pkg and the RTL.
`timescale 1ns / 100ps
module testbench;
  import perb_pkg::*;

  localparam int NILV = 255;

  typedef struct {
    action_t            act;
    logic [PAY_W-1:0]   pay;
    logic [PRIO_W-1:0]  prio;
    logic [USER_W-1:0]  user;
    logic               deliv;
  } req_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [1:0] in_action = '0;
  logic [PAY_W-1:0] in_payload = '0;
  logic [PRIO_W-1:0] in_priority_req = '0;
  logic [USER_W-1:0] in_user_id = '0;
  logic in_delivered = 0;
  logic out_valid, out_ready = 0;
  logic out_ok, out_evicted_active, out_nothing_pending;
  logic [PAY_W-1:0] out_payload;
  logic [USER_W-1:0] out_user;
  logic [PRIO_W-1:0] out_priority;
  logic cfg_we = 0;
  logic [RETRY_W-1:0] cfg_wdata = '0;

  priority_event_retry_buffer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_payload(in_payload), .in_priority_req(in_priority_req),
    .in_user_id(in_user_id), .in_delivered(in_delivered),
    .out_valid(out_valid), .out_ready(out_ready), .out_ok(out_ok),
    .out_payload(out_payload), .out_user(out_user), .out_priority(out_priority),
    .out_evicted_active(out_evicted_active), .out_nothing_pending(out_nothing_pending),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor copy of the slot store
  logic [FLAG_W-1:0]  sf [SLOTS];
  logic [PRIO_W-1:0]  sp [SLOTS];
  logic [USER_W-1:0]  so [SLOTS];
  logic [PAY_W-1:0]   sd [SLOTS];
  logic [RETRY_W-1:0] sr [SLOTS];
  int sn [SLOTS];
  int sv [SLOTS];
  int head_s, tail_s, probe_s;
  logic [RETRY_W-1:0] retry_lim;

  req_t pend_reqs[$];
  result_t exp_results[$];
  req_t cur_req;
  bit in_busy = 0;
  int stall_pct = 32;
  bit hold_req = 0;
  int hold_left = 0;
  int errors = 0;

  function automatic bit is_act(int s);
    return (sf[s] & (F_USED | F_ACTIVE)) == (F_USED | F_ACTIVE);
  endfunction

  function automatic bit is_pend(int s);
    return is_act(s) && (sf[s] & (F_PROC | F_FAIL)) == 0;
  endfunction

  function automatic int follow(int s);
    return sn[s] < SLOTS ? sn[s] : NILV;
  endfunction

  function automatic void unlink(int s);
    int p, n;
    if (s >= SLOTS || sf[s] == 0) return;
    sf[s] = 0;
    p = sv[s];
    n = sn[s];
    if (s != head_s) begin
      if (p < SLOTS) sn[p] = n;
      if (tail_s == s) begin
        tail_s = p;
        return;
      end
      if (n < SLOTS) sv[n] = p;
      return;
    end
    if (s != tail_s) begin
      if (n < SLOTS) begin
        head_s = n;
        sv[n] = NILV;
      end
    end else tail_s = NILV;
  endfunction

  function automatic bit none_pending();
    int s;
    s = head_s % SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (is_pend(s)) return 0;
      s = follow(s);
      if (s == NILV) break;
    end
    return 1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < SLOTS; i++) begin
      probe_s = (probe_s + 1 >= SLOTS) ? 0 : probe_s + 1;
      if (sf[probe_s] == 0) return probe_s;
    end
    return NILV;
  endfunction

  function automatic int find_victim(int prio);
    int s, low;
    s = head_s % SLOTS;
    low = PRIO_MAX;
    for (int i = 0; i < SLOTS; i++) begin
      if (sf[s] == 0) return s;
      if (sp[s] < low) low = sp[s];
      s = follow(s);
      if (s == NILV) break;
    end
    if (low > prio) return NILV;
    s = head_s % SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (sp[s] == low) return s;
      s = follow(s);
      if (s == NILV) break;
    end
    return NILV;
  endfunction

  // apply one request to the store copy and return its result
  function automatic result_t apply_request(req_t r);
    result_t res;
    int s, n, w;
    res = '0;
    case (r.act)
      ACT_ADD: begin
        w = NILV;
        if (r.user != 0) begin
          if (tail_s == NILV) w = head_s % SLOTS;
          else begin
            w = find_free();
            if (w == NILV) begin
              w = find_victim(r.prio);
              if (w != NILV) begin
                if (sf[w] & F_ACTIVE) res.evicted = 1;
                unlink(w);
              end
            end
          end
        end
        if (w != NILV) begin
          sd[w] = r.pay; sp[w] = r.prio; so[w] = r.user; sr[w] = 0;
          sf[w] = F_USED | F_ACTIVE;
          sn[w] = NILV;
          if (tail_s < SLOTS) sn[tail_s] = w;
          sv[w] = tail_s;
          tail_s = w;
          res.ok = 1;
        end
      end
      ACT_GET: begin
        s = head_s % SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
          if (is_pend(s) && (r.user == 0 || r.user == so[s])) begin
            sf[s] |= F_PROC;
            res.ok = 1; res.payload = sd[s]; res.user = so[s]; res.prio = sp[s];
            break;
          end
          s = follow(s);
          if (s == NILV) break;
        end
      end
      ACT_DONE: begin
        s = head_s % SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
          n = follow(s);
          if (sf[s] & F_PROC) begin
            sf[s] &= ~F_PROC;
            if (is_act(s)) begin
              if (r.deliv) unlink(s);
              else sf[s] |= F_FAIL;
            end
          end
          if (n == NILV) break;
          s = n;
        end
      end
      default: begin
        res.ok = 1;
        s = head_s % SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
          n = follow(s);
          if (sf[s] & (F_PROC | F_FAIL)) begin
            sf[s] &= ~(F_PROC | F_FAIL);
            if (is_act(s) && retry_lim != 0) begin
              sr[s] = sr[s] + 1'b1;
              if (sr[s] >= retry_lim) begin
                unlink(s);
                res.ok = 0;
              end
            end
          end
          if (n == NILV) break;
          s = n;
        end
      end
    endcase
    res.nothing_pending = none_pending();
    return res;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!in_busy) begin
      if (pend_reqs.size() > 0 && $urandom_range(0, 99) >= stall_pct) begin
        cur_req = pend_reqs.pop_front();
        in_valid <= 1;
        in_action <= cur_req.act;
        in_payload <= cur_req.pay;
        in_priority_req <= cur_req.prio;
        in_user_id <= cur_req.user;
        in_delivered <= cur_req.deliv;
        in_busy = 1;
      end else in_valid <= 0;
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      out_ready <= 0;
    end else out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // accept monitor and result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && in_valid && in_ready && in_busy) begin
      exp_results.push_back(apply_request(cur_req));
      in_busy = 0;
    end
    if (rst_n && out_valid && out_ready) begin
      if (exp_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = exp_results.pop_front();
        if (out_ok !== e.ok) begin
          $error("ok: expected %0d got %0d", e.ok, out_ok); errors++;
        end
        if (out_payload !== e.payload) begin
          $error("payload: expected %h got %h", e.payload, out_payload); errors++;
        end
        if (out_user !== e.user) begin
          $error("user: expected %h got %h", e.user, out_user); errors++;
        end
        if (out_priority !== e.prio) begin
          $error("priority: expected %0d got %0d", e.prio, out_priority); errors++;
        end
        if (out_evicted_active !== e.evicted) begin
          $error("evicted_active: expected %0d got %0d", e.evicted, out_evicted_active);
          errors++;
        end
        if (out_nothing_pending !== e.nothing_pending) begin
          $error("nothing_pending: expected %0d got %0d", e.nothing_pending,
                 out_nothing_pending);
          errors++;
        end
      end
    end
  end

  task automatic queue_req(action_t a, logic [PAY_W-1:0] p, logic [PRIO_W-1:0] pr,
                           logic [USER_W-1:0] u, logic d);
    req_t r;
    r.act = a; r.pay = p; r.prio = pr; r.user = u; r.deliv = d;
    pend_reqs.push_back(r);
  endtask

  function automatic logic [USER_W-1:0] rand_user(bit allow_zero);
    int k;
    k = $urandom_range(0, 99);
    if (allow_zero && k < 30) return 0;
    if (k < 80) return USER_W'($urandom_range(1, 4));
    return USER_W'($urandom_range(1, 65535));
  endfunction

  task automatic queue_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40)
        queue_req(ACT_ADD, $urandom, PRIO_W'($urandom_range(0, 7)),
                  ($urandom_range(0, 19) == 0) ? 16'h0 : rand_user(0),
                  1'($urandom_range(0, 1)));
      else if (k < 70)
        queue_req(ACT_GET, $urandom, PRIO_W'($urandom_range(0, 7)), rand_user(1),
                  1'($urandom_range(0, 1)));
      else if (k < 85)
        queue_req(ACT_DONE, $urandom, PRIO_W'($urandom_range(0, 7)), USER_W'($urandom),
                  1'($urandom_range(0, 1)));
      else
        queue_req(ACT_RESTORE, $urandom, PRIO_W'($urandom_range(0, 7)), USER_W'($urandom),
                  1'($urandom_range(0, 1)));
    end
  endtask

  // wait until no request is queued or outstanding, then let the block settle
  task automatic drain();
    while (pend_reqs.size() > 0 || in_busy || exp_results.size() > 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_limit(logic [RETRY_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    retry_lim = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // run timeout
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [RETRY_W-1:0] limits [5];
    limits = '{8'd1, 8'd3, 8'd255, 8'd2, 8'd0};
    for (int i = 0; i < SLOTS; i++) begin
      sf[i] = 0; sp[i] = 0; so[i] = 0; sd[i] = 0; sr[i] = 0;
      sn[i] = NILV; sv[i] = NILV;
    end
    head_s = 0; tail_s = NILV; probe_s = SLOTS - 1; retry_lim = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    write_limit(8'd0);

    // directed: refused add, empty ops, field extremes, filters, full store
    queue_req(ACT_ADD, 32'h1234, 3'd1, 16'h0, 1'b0);
    queue_req(ACT_GET, 32'h0, 3'd0, 16'h0, 1'b0);
    queue_req(ACT_DONE, 32'h0, 3'd0, 16'h0, 1'b1);
    queue_req(ACT_RESTORE, 32'h0, 3'd0, 16'h0, 1'b0);
    queue_req(ACT_ADD, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 1'b1);
    queue_req(ACT_ADD, 32'h0, 3'd0, 16'h1, 1'b0);
    queue_req(ACT_GET, 32'h0, 3'd0, 16'h2, 1'b0);
    queue_req(ACT_GET, 32'h0, 3'd0, 16'h1, 1'b0);
    queue_req(ACT_GET, 32'h0, 3'd0, 16'h0, 1'b0);
    queue_req(ACT_DONE, 32'h0, 3'd0, 16'h0, 1'b0);
    queue_req(ACT_RESTORE, 32'h0, 3'd0, 16'h0, 1'b0);
    for (int i = 0; i < 15; i++)
      queue_req(ACT_ADD, 32'hA5A5_0000 + i, 3'(i % 3 + 1), 16'h3, 1'b0);
    queue_req(ACT_ADD, 32'hDEAD_BEEF, 3'd0, 16'h4, 1'b0);
    queue_req(ACT_ADD, 32'hCAFE_F00D, 3'd7, 16'h4, 1'b0);
    drain();

    // random phases over several retry limits
    foreach (limits[i]) begin
      write_limit(limits[i]);
      if (i == 1) hold_req = 1;
      if (i == 2) stall_pct = 0;
      else stall_pct = 32;
      queue_random(225);
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
